@@ sv/epwd_pkg.sv @@
package epwd_pkg;

  localparam int CAPT_W = 16;
  localparam int WRAP_W = 6;
  localparam int DIST_W = 20;
  localparam int TICK_W = 22;

  localparam logic [WRAP_W-1:0] MAX_WRAPS      = 6'h3F;
  localparam logic [CAPT_W-1:0] OVERFLOW_COUNT = 16'hFFFF;
  localparam logic [CAPT_W-1:0] RELOAD_RESET   = 16'd49999;

  // Ticks times 0.172, as a multiply by ceil(0.172 * 2^32) and a shift by 32.
  // It is exact for every tick count below 2^22.
  localparam int SCALE_W     = 30;
  localparam int SCALE_SHIFT = 32;
  localparam logic [SCALE_W-1:0] MM_SCALE = 30'd738734375;

  localparam logic [DIST_W-1:0] MAX_DISTANCE = 20'd721420;

  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic              measured;
    logic [WRAP_W-1:0] wraps;
    logic [CAPT_W-1:0] latched;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ sv/epwd_if.sv @@
interface epwd_in_if;
  import epwd_pkg::*;

  logic              valid;
  logic              ready;
  logic              timer_wrap;
  logic              edge_seen;
  logic [CAPT_W-1:0] captured_count;
  logic              read_request;

  modport source (output valid, timer_wrap, edge_seen, captured_count, read_request,
                  input ready);
  modport sink (input valid, timer_wrap, edge_seen, captured_count, read_request,
                output ready);
endinterface

interface epwd_out_if;
  import epwd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_mm;
  logic              measured;

  modport source (output valid, distance_mm, measured, input ready);
  modport sink (input valid, distance_mm, measured, output ready);
endinterface

interface epwd_cfg_if;
  import epwd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CAPT_W-1:0] reload_value;

  modport source (output valid, reload_value, input ready);
  modport sink (input valid, reload_value, output ready);
endinterface

@@ sv/epwd_queue.sv @@
module epwd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  epwd_pkg::job_t      push_data,
  input  logic                pop,
  output epwd_pkg::job_t      pop_data,
  output epwd_pkg::q_status_t status
);
  import epwd_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(Q_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(Q_DEPTH);

  job_t             entry_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = entry_r[rd_ptr_r];
  assign status.full  = (cnt_r == FULL_CNT);
  assign status.empty = (cnt_r == '0);

endmodule

@@ sv/epwd_front.sv @@
module epwd_front (
  input  logic                clk,
  input  logic                rst_n,
  epwd_in_if.sink             in_ch,
  input  epwd_pkg::q_status_t q_stat,
  output logic                job_push,
  output epwd_pkg::job_t      job
);
  import epwd_pkg::*;

  logic              done_r, done_nxt, done_ev;
  logic              high_r, high_nxt, high_ev;
  logic [WRAP_W-1:0] wrap_r, wrap_nxt, wrap_ev;
  logic [CAPT_W-1:0] lat_r, lat_nxt, lat_ev;
  logic              accept;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Wrap, then edge, then read; an edge overrides what the wrap left, and the read sees what both left.
  always_comb begin
    done_ev = done_r;
    high_ev = high_r;
    wrap_ev = wrap_r;
    lat_ev  = lat_r;
    if (!done_r) begin
      if (in_ch.timer_wrap && high_r) begin
        if (wrap_r == MAX_WRAPS) begin
          done_ev = 1'b1;
          lat_ev  = OVERFLOW_COUNT;
        end else begin
          wrap_ev = wrap_r + 1'b1;
        end
      end
      if (in_ch.edge_seen) begin
        if (high_r) begin
          done_ev = 1'b1;
          lat_ev  = in_ch.captured_count;
        end else begin
          done_ev = 1'b0;
          high_ev = 1'b1;
          wrap_ev = '0;
          lat_ev  = '0;
        end
      end
    end

    job.measured = in_ch.read_request && done_ev;
    job.wraps    = wrap_ev;
    job.latched  = lat_ev;

    if (in_ch.read_request) begin
      done_nxt = 1'b0;
      high_nxt = 1'b0;
      wrap_nxt = '0;
      lat_nxt  = '0;
    end else begin
      done_nxt = done_ev;
      high_nxt = high_ev;
      wrap_nxt = wrap_ev;
      lat_nxt  = lat_ev;
    end
  end

  assign job_push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
      high_r <= 1'b0;
      wrap_r <= '0;
      lat_r  <= '0;
    end else if (accept) begin
      done_r <= done_nxt;
      high_r <= high_nxt;
      wrap_r <= wrap_nxt;
      lat_r  <= lat_nxt;
    end
  end

endmodule

@@ sv/epwd_back.sv @@
module epwd_back (
  input  logic                clk,
  input  logic                rst_n,
  epwd_cfg_if.sink            cfg_ch,
  input  epwd_pkg::q_status_t q_stat,
  input  epwd_pkg::job_t      job,
  output logic                job_pop,
  epwd_out_if.source          out_ch
);
  import epwd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TICKS = 2'd1;
  localparam logic [1:0] ST_SCALE = 2'd2;

  localparam int SCALED_W = TICK_W + SCALE_W;

  logic [1:0]          state_r, state_nxt;
  logic [CAPT_W-1:0]   reload_r;
  job_t                job_r;
  logic [TICK_W-1:0]   ticks_r, ticks_nxt;
  logic [TICK_W-1:0]   ticks_full;
  logic [SCALED_W-1:0] scaled;
  logic                out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]   out_dist_r;
  logic                out_meas_r;
  logic                out_free;
  logic                load_out;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= RELOAD_RESET;
    end else if (cfg_ch.valid) begin
      reload_r <= cfg_ch.reload_value;
    end
  end

  assign ticks_full = TICK_W'(job_r.wraps) * (TICK_W'(reload_r) + TICK_W'(1))
                    + TICK_W'(job_r.latched);
  assign ticks_nxt  = job_r.measured ? ticks_full : '0;
  assign scaled     = SCALED_W'(ticks_r) * SCALED_W'(MM_SCALE);

  assign out_free = !out_valid_r || out_ch.ready;
  assign job_pop  = (state_r == ST_IDLE) && !q_stat.empty;
  assign load_out = (state_r == ST_SCALE) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = ST_TICKS;
        end
      end
      ST_TICKS: begin
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job;
    end
    if (state_r == ST_TICKS) begin
      ticks_r <= ticks_nxt;
    end
    if (load_out) begin
      out_dist_r <= scaled[SCALE_SHIFT +: DIST_W];
      out_meas_r <= job_r.measured;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.distance_mm = out_dist_r;
  assign out_ch.measured    = out_meas_r;

endmodule

@@ sv/echo_pulse_width_distance.sv @@
// An accepted word passes the queue, job, tick and output registers; the back end
// pops a new word only after the tick and scale multiplies of the last one.
// The front end takes a new word each cycle until the two-entry queue fills.
// Synchronous active-low reset clears the capture state, the queue and the output
// valid flag, and sets the reload register to 49999.
module echo_pulse_width_distance (
  input  logic       clk,
  input  logic       rst_n,
  epwd_in_if.sink    in_ch,
  epwd_cfg_if.sink   cfg_ch,
  epwd_out_if.source out_ch
);
  import epwd_pkg::*;

  job_t      push_job;
  job_t      pop_job;
  logic      job_push;
  logic      job_pop;
  q_status_t q_stat;

  epwd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .job_push (job_push),
    .job      (push_job)
  );

  epwd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (push_job),
    .pop       (job_pop),
    .pop_data  (pop_job),
    .status    (q_stat)
  );

  epwd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .q_stat  (q_stat),
    .job     (pop_job),
    .job_pop (job_pop),
    .out_ch  (out_ch)
  );

  a_no_read_no_measure: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !in_ch.read_request) |-> !push_job.measured)
    else $error("word without a read was queued as measured");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_zero_unmeasured: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.measured) |-> (out_ch.distance_mm == '0))
    else $error("nonzero distance without a measurement");

  a_distance_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.distance_mm <= MAX_DISTANCE))
    else $error("distance above the largest possible value");

endmodule
